// ===== design/three_wheel_odometry_integrator_top_macros.svh =====
// Assertion macros for the three-wheel odometry integrator.
// Used by three_wheel_odometry_integrator_top; expects clk and rst_n in scope.
`ifndef THREE_WHEEL_ODOMETRY_INTEGRATOR_TOP_MACROS_SVH
`define THREE_WHEEL_ODOMETRY_INTEGRATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TWOI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication
`define TWOI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TWOI_ASSERT_NOW(lbl, ante, cons, msg)
`define TWOI_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/twoi_pkg.sv =====
// Package for the three-wheel odometry integrator: payload types, register
// indexes, sequencer states, CORDIC constants and saturation helper. No dependencies.
`timescale 1ns / 1ps
package twoi_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam logic signed [32:0] GAIN_START = 33'sd652032874;

  typedef struct packed {
    logic              command;
    logic signed [15:0] count_left;
    logic signed [15:0] count_front;
    logic signed [15:0] count_right;
  } twoi_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] heading;
    logic signed [31:0] step_forward;
    logic signed [31:0] step_sideways;
    logic signed [31:0] step_turn;
  } twoi_out_t;

  typedef enum logic [2:0] {
    REG_SIGN_FLIPS = 3'd0,
    REG_DIST_PER_COUNT = 3'd1,
    REG_TURN_GAIN = 3'd2,
    REG_START_X = 3'd3,
    REG_START_Y = 3'd4,
    REG_START_HEADING = 3'd5
  } twoi_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_D0, ST_D1, ST_D2, ST_D3, ST_T0, ST_T1, ST_T2, ST_T3,
    ST_COR, ST_W0, ST_W1, ST_W2, ST_W3, ST_W4, ST_OUT
  } twoi_state_t;

  localparam logic signed [31:0] ATAN_TAB [32] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772, 32'sd166886,
    32'sd83443, 32'sd41722, 32'sd20861, 32'sd10430, 32'sd5215, 32'sd2608,
    32'sd1304, 32'sd652, 32'sd326, 32'sd163, 32'sd81, 32'sd41, 32'sd20,
    32'sd10, 32'sd5, 32'sd3, 32'sd1, 32'sd1, 32'sd0
  };

  // Clamp a wide signed value to 32 bits signed
  function automatic logic signed [31:0] sat32(input logic signed [75:0] v);
    if (v > 76'sh0_0000_0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -76'sh0_0000_0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

// ===== design/three_wheel_odometry_integrator_top.sv =====
// Three-wheel odometry integrator top: sequencer around one shared 33x33
// multiplier and one shift-add CORDIC unit. Uses twoi_pkg and the macro header.
//
//  channel | ports                       | request moves
//  in      | in_valid/in_stall/in_data   | command and three count deltas
//  out     | out_valid/out_stall/out_data| pose, heading and step
//  cfg     | cfg_we/cfg_addr/cfg_wdata   | one register write
//
// An integrate request runs the distance, turn, CORDIC and pose-update states, with the
// products on the shared multiplier. A set request goes straight to the output state.
// in_stall is high from acceptance until the result moves to the output register;
// a result waiting under out_stall blocks only the next result, not acceptance.
// Reset (rst_n low, synchronous) clears pose, registers and control.
`timescale 1ns / 1ps
`include "three_wheel_odometry_integrator_top_macros.svh"
module three_wheel_odometry_integrator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  twoi_pkg::twoi_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output twoi_pkg::twoi_out_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import twoi_pkg::*;

  twoi_state_t state_r, state_nxt;

  logic [2:0]         flips_r;
  logic [23:0]        dpc_r;
  logic [31:0]        tg_r;
  logic signed [31:0] start_x_r, start_y_r, start_h_r;

  logic signed [16:0] cl_r, cf_r, cr_r;
  logic signed [40:0] d0_r, d1_r;
  logic signed [41:0] diff_r;
  logic signed [31:0] fwd_r, side_r, turn_r;
  logic signed [75:0] acc_r;
  logic signed [65:0] prod_r;
  logic signed [32:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic [5:0]         iter_r;
  logic signed [31:0] pos_x_r, pos_y_r;
  logic [31:0]        angle_r;
  logic               out_valid_r;
  twoi_out_t          out_r;

  logic               in_acc, out_free;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flips_r <= '0; dpc_r <= '0; tg_r <= '0;
      start_x_r <= '0; start_y_r <= '0; start_h_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SIGN_FLIPS:     flips_r <= cfg_wdata[2:0];
        REG_DIST_PER_COUNT: dpc_r <= cfg_wdata[23:0];
        REG_TURN_GAIN:      tg_r <= cfg_wdata;
        REG_START_X:        start_x_r <= cfg_wdata;
        REG_START_Y:        start_y_r <= cfg_wdata;
        REG_START_HEADING:  start_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = in_data.command ? ST_OUT : ST_D0;
      ST_D0:   state_nxt = ST_D1;
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_D3;
      ST_D3:   state_nxt = ST_T0;
      ST_T0:   state_nxt = ST_T1;
      ST_T1:   state_nxt = ST_T2;
      ST_T2:   state_nxt = ST_T3;
      ST_T3:   state_nxt = ST_COR;
      ST_COR:  if (iter_r == 6'(CORDIC_STEPS - 1)) state_nxt = ST_W0;
      ST_W0:   state_nxt = ST_W1;
      ST_W1:   state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_W3;
      ST_W3:   state_nxt = ST_W4;
      ST_W4:   state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs and shared multiplier operand select
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    ma = '0;
    mb = '0;
    unique case (state_r)
      ST_D0: begin ma = 33'(cl_r); mb = {9'b0, dpc_r}; end
      ST_D1: begin ma = 33'(cf_r); mb = {9'b0, dpc_r}; end
      ST_D2: begin ma = 33'(cr_r); mb = {9'b0, dpc_r}; end
      ST_T0: begin ma = {12'b0, diff_r[20:0]}; mb = {1'b0, tg_r}; end
      ST_T1: begin ma = 33'($signed(diff_r[41:21])); mb = {1'b0, tg_r}; end
      ST_W0: begin ma = 33'(fwd_r); mb = cx_r; end
      ST_W1: begin ma = 33'(side_r); mb = cy_r; end
      ST_W2: begin ma = 33'(fwd_r); mb = cy_r; end
      ST_W3: begin ma = 33'(side_r); mb = cx_r; end
      default: ;
    endcase
    prod_nxt = ma * mb;
  end

  // Step arithmetic and CORDIC working values
  logic signed [41:0] diff_w, sum_w;
  logic signed [43:0] fwd_w, side_w;
  logic signed [31:0] turn_w, z0_w;
  logic [31:0]        mid_w;
  logic               flip_w;
  logic [4:0]         sh;
  logic signed [32:0] xs, ys, at, nx, ny, nz;
  logic signed [31:0] wx_w, wy_w;

  always_comb begin
    diff_w = 42'(prod_r) - 42'(d0_r);
    sum_w  = 42'(prod_r) + 42'(d0_r);
    fwd_w  = (44'(sum_w) + 44'sd256) >>> 9;
    side_w = ((44'(d1_r) <<< 1) - 44'(diff_w) + 44'sd256) >>> 9;
    turn_w = sat32((acc_r + (76'sd1 <<< 40)) >>> 41);
    mid_w  = angle_r + 32'(turn_w >>> 1);
    z0_w   = mid_w;
    flip_w = 1'b0;
    if (z0_w > 32'sd1073741824 || z0_w < -32'sd1073741824) begin
      z0_w   = mid_w ^ 32'h8000_0000;
      flip_w = 1'b1;
    end
    sh = iter_r[4:0];
    xs = cx_r >>> sh;
    ys = cy_r >>> sh;
    at = 33'(ATAN_TAB[sh]);
    if (!cz_r[32]) begin
      nx = cx_r - ys; ny = cy_r + xs; nz = cz_r - at;
    end else begin
      nx = cx_r + ys; ny = cy_r - xs; nz = cz_r + at;
    end
    if (iter_r == 6'(CORDIC_STEPS - 1) && flip_r) begin
      nx = -nx; ny = -ny;
    end
    // x uses acc in the last multiply state, y the sum of the last two products after it
    wx_w = sat32(76'(pos_x_r) + ((acc_r + (76'sd1 <<< 29)) >>> 30));
    wy_w = sat32(76'(pos_y_r) + ((acc_r + 76'(prod_r) + (76'sd1 <<< 29)) >>> 30));
  end

  // Sequencer state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r <= '0;
      out_valid_r <= 1'b0;
      pos_x_r <= '0; pos_y_r <= '0; angle_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_T3) iter_r <= '0;
      else if (state_r == ST_COR) iter_r <= iter_r + 6'd1;
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_IDLE && in_acc && in_data.command) begin
        pos_x_r <= start_x_r; pos_y_r <= start_y_r; angle_r <= start_h_r;
      end
      if (state_r == ST_W3) begin
        pos_x_r <= wx_w;
        angle_r <= angle_r + turn_r;
      end
      if (state_r == ST_W4) pos_y_r <= wy_w;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    unique case (state_r)
      ST_IDLE: begin
        cl_r <= flips_r[0] ? -17'(in_data.count_left)  : 17'(in_data.count_left);
        cf_r <= flips_r[1] ? -17'(in_data.count_front) : 17'(in_data.count_front);
        cr_r <= flips_r[2] ? -17'(in_data.count_right) : 17'(in_data.count_right);
        fwd_r <= '0; side_r <= '0; turn_r <= '0;
      end
      ST_D1: d0_r <= prod_r[40:0];
      ST_D2: d1_r <= prod_r[40:0];
      ST_D3: begin
        diff_r <= diff_w;
        fwd_r  <= sat32(76'(fwd_w));
        side_r <= sat32(76'(side_w));
      end
      ST_T1: acc_r <= 76'(prod_r);
      ST_T2: acc_r <= acc_r + (76'(prod_r) <<< 21);
      ST_T3: begin
        turn_r <= turn_w;
        cx_r <= GAIN_START; cy_r <= '0; cz_r <= 33'(z0_w); flip_r <= flip_w;
      end
      ST_COR: begin cx_r <= nx; cy_r <= ny; cz_r <= nz; end
      ST_W1: acc_r <= 76'(prod_r);
      ST_W2: acc_r <= acc_r - 76'(prod_r);
      ST_W3: acc_r <= 76'(prod_r);
      default: ;
    endcase
    if (state_r == ST_OUT && out_free) begin
      out_r.pose_x <= pos_x_r;
      out_r.pose_y <= pos_y_r;
      out_r.heading <= angle_r;
      out_r.step_forward <= fwd_r;
      out_r.step_sideways <= side_r;
      out_r.step_turn <= turn_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks on the sequencer
  `TWOI_ASSERT_NXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE, "accepted request did not start")
  `TWOI_ASSERT_NOW(a_iter_bound, state_r == ST_COR, iter_r < 6'(CORDIC_STEPS), "CORDIC overrun")
  `TWOI_ASSERT_NOW(a_result_from_out, $rose(out_valid_r), $past(state_r) == ST_OUT, "stray result")
  `TWOI_ASSERT_NOW(a_no_accept_busy, state_r != ST_IDLE, in_stall, "accepting while busy")

endmodule

// ===== test/tb_three_wheel_odometry_integrator_top.sv =====
// Self-checking testbench for three_wheel_odometry_integrator_top: directed tables plus
// random requests, checked against an in-bench odometry predictor. Depends on twoi_pkg.
`timescale 1ns / 1ps
module tb_three_wheel_odometry_integrator_top;
  import twoi_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    twoi_in_t  req;
    bit        fixed;
    twoi_out_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  twoi_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  twoi_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // predictor copy of registers and pose
  logic [2:0]  flips_m;
  logic [23:0] dist_m;
  logic [31:0] gain_m;
  longint      start_x_m, start_y_m;
  logic [31:0] start_hd_m;
  longint      pos_x_m, pos_y_m;
  logic [31:0] angle_m;

  twoi_out_t pose_q[$];
  stim_row_t tab_reset[$];
  stim_row_t tab_extreme[$];
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  long_hold_req = 0;

  three_wheel_odometry_integrator_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // add half, then floor
  function automatic longint round_down(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // advance the pose by one request and return the result it should produce
  function automatic twoi_out_t odo_predict(twoi_in_t r);
    longint cnt[3];
    longint d[3];
    longint diff, fwd, side, turn, cx, sy, z, nx;
    logic [31:0] mid;
    bit flip;
    twoi_out_t o;
    fwd = 0; side = 0; turn = 0;
    if (r.command) begin
      pos_x_m = start_x_m;
      pos_y_m = start_y_m;
      angle_m = start_hd_m;
    end else begin
      cnt[0] = longint'(r.count_left);
      cnt[1] = longint'(r.count_front);
      cnt[2] = longint'(r.count_right);
      for (int k = 0; k < 3; k++) begin
        if (flips_m[k]) cnt[k] = -cnt[k];
        d[k] = cnt[k] * longint'({40'd0, dist_m});
      end
      diff = d[2] - d[0];
      fwd = clamp32(round_down(d[0] + d[2], 9));
      side = clamp32(round_down(2 * d[1] - diff, 9));
      turn = clamp32((diff * longint'({48'd0, gain_m[31:16]}) + (64'sd1 <<< 24)
                      + ((diff * longint'({48'd0, gain_m[15:0]})) >>> 16)) >>> 25);
      mid = angle_m + 32'(turn >>> 1);
      // sine and cosine by rotation-mode CORDIC, folded into +-pi/2
      flip = 0;
      z = longint'($signed(mid));
      if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
        z = longint'($signed(mid ^ 32'h8000_0000));
        flip = 1;
      end
      cx = longint'(GAIN_START);
      sy = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        if (z >= 0) begin
          nx = cx - (sy >>> i);
          sy = sy + (cx >>> i);
          z -= longint'(ATAN_TAB[i]);
        end else begin
          nx = cx + (sy >>> i);
          sy = sy - (cx >>> i);
          z += longint'(ATAN_TAB[i]);
        end
        cx = nx;
      end
      if (flip) begin
        cx = -cx;
        sy = -sy;
      end
      pos_x_m = clamp32(pos_x_m + round_down(fwd * cx - side * sy, 30));
      pos_y_m = clamp32(pos_y_m + round_down(fwd * sy + side * cx, 30));
      angle_m = angle_m + 32'(turn);
    end
    o.pose_x = 32'(pos_x_m);
    o.pose_y = 32'(pos_y_m);
    o.heading = angle_m;
    o.step_forward = 32'(fwd);
    o.step_sideways = 32'(side);
    o.step_turn = 32'(turn);
    return o;
  endfunction

  function automatic stim_row_t mk_row(bit cmd, int l, int f, int r, bit fx, twoi_out_t w);
    stim_row_t s;
    s.req.command = cmd;
    s.req.count_left = 16'(l);
    s.req.count_front = 16'(f);
    s.req.count_right = 16'(r);
    s.fixed = fx;
    s.want = w;
    return s;
  endfunction

  // offer one request after a random gap, hold it until accepted
  task automatic send_req(twoi_in_t r, bit fx, twoi_out_t w);
    int sel, gap;
    twoi_out_t pr;
    sel = $urandom_range(0, 99);
    gap = (sel < 65) ? 0 : (sel < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pr = odo_predict(r);
    pose_q.push_back(fx ? w : pr);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_SIGN_FLIPS:     flips_m = val[2:0];
      REG_DIST_PER_COUNT: dist_m = val[23:0];
      REG_TURN_GAIN:      gain_m = val;
      REG_START_X:        start_x_m = longint'($signed(val));
      REG_START_Y:        start_y_m = longint'($signed(val));
      REG_START_HEADING:  start_hd_m = val;
      default: ;
    endcase
  endtask

  // drain all results, then let the sequencer go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic load_regs(logic [2:0] fl, logic [23:0] dpc, logic [31:0] g,
                           logic [31:0] sx, logic [31:0] sy, logic [31:0] sh);
    write_reg(REG_SIGN_FLIPS, {29'd0, fl});
    write_reg(REG_DIST_PER_COUNT, {8'd0, dpc});
    write_reg(REG_TURN_GAIN, g);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_HEADING, sh);
  endtask

  // result side: random stalls, with a long hold on request
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      out_stall <= 1'b1;
      stall_left <= 400;
    end else begin
      int sel;
      sel = $urandom_range(0, 99);
      out_stall <= (sel < 40);
      stall_left <= (sel < 5) ? $urandom_range(20, 60) : (sel < 15) ? $urandom_range(30, 80)
                    : $urandom_range(0, 3);
    end
  end

  // compare each delivered result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      twoi_out_t want;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = pose_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (out_data[191 - 32 * k -: 32] !== want[191 - 32 * k -: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h got %h", k,
                       want[191 - 32 * k -: 32], out_data[191 - 32 * k -: 32]);
          end
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    twoi_out_t zero_out, set_out;
    twoi_in_t  r;
    int sel;
    zero_out = '0;
    flips_m = '0; dist_m = '0; gain_m = '0;
    start_x_m = 0; start_y_m = 0; start_hd_m = '0;
    pos_x_m = 0; pos_y_m = 0; angle_m = '0;

    // registers at reset: nothing moves, set loads zero
    tab_reset.push_back(mk_row(0, 32767, -32768, 32767, 1, zero_out));
    tab_reset.push_back(mk_row(0, -32768, 32767, -32768, 1, zero_out));
    tab_reset.push_back(mk_row(1, 0, 0, 0, 1, zero_out));
    tab_reset.push_back(mk_row(0, 12, -7, 300, 1, zero_out));

    // largest scale and gain: saturating steps, wrapping heading
    set_out = '0;
    set_out.pose_x = 32'sh7FFF_FFFF;
    set_out.pose_y = 32'sh8000_0000;
    set_out.heading = 32'sh8000_0000;
    tab_extreme.push_back(mk_row(1, 32767, 32767, 32767, 1, set_out));
    tab_extreme.push_back(mk_row(0, 32767, 32767, 32767, 0, zero_out));
    tab_extreme.push_back(mk_row(0, -32768, -32768, -32768, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 32767, 0, -32768, 0, zero_out));
    tab_extreme.push_back(mk_row(0, -32768, 0, 32767, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 0, 32767, 0, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 0, -32768, 0, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 0, 0, 0, 0, zero_out));
    tab_extreme.push_back(mk_row(0, -1, 1, 1, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 100, -100, 200, 0, zero_out));
    tab_extreme.push_back(mk_row(1, -1, -1, -1, 1, set_out));
    tab_extreme.push_back(mk_row(0, 1, 0, -1, 0, zero_out));
    tab_extreme.push_back(mk_row(0, 5000, 3000, -5000, 0, zero_out));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tab_reset[i]) send_req(tab_reset[i].req, tab_reset[i].fixed, tab_reset[i].want);
    settle();
    load_regs(3'b101, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    // writes past the register list are dropped
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0000_0000);
    foreach (tab_extreme[i])
      send_req(tab_extreme[i].req, tab_extreme[i].fixed, tab_extreme[i].want);

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: load_regs(3'b111, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF);
        1: load_regs(3'b000, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        default: load_regs(3'($urandom), ($urandom_range(0, 3) == 0) ? 24'($urandom)
                           : 24'($urandom_range(1, 70000)), $urandom, $urandom, $urandom,
                           $urandom);
      endcase
      for (int n = 0; n < 250; n++) begin
        if (ph == 2 && n == 40) long_hold_req = 1;
        if (ph == 3 && n == 100) begin
          in_valid <= 1'b0;
          while (pose_q.size() != 0) @(posedge clk);
        end
        sel = $urandom_range(0, 99);
        r.command = ($urandom_range(0, 19) == 0);
        if (sel < 25) begin
          r.count_left = 16'($urandom);
          r.count_front = 16'($urandom);
          r.count_right = 16'($urandom);
        end else begin
          r.count_left = 16'(int'($urandom_range(0, 600)) - 300);
          r.count_front = 16'(int'($urandom_range(0, 600)) - 300);
          r.count_right = 16'(int'($urandom_range(0, 600)) - 300);
        end
        send_req(r, 0, zero_out);
      end
    end

    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
